FILE: rtl/core/gal_pkg.sv
// ----------------------------------------------------------------------------
// gal_pkg
// Shared types and constants of the glyph atlas lookup block.
// ----------------------------------------------------------------------------
package gal_pkg;

	localparam int CODE_W    = 16;
	localparam int IMG_W     = 15;
	localparam int OFS_W     = 14;
	localparam int CFG_IDX_W = 4;
	localparam int DIV_CNT_W = $clog2(IMG_W + 1);

	localparam logic [CODE_W-1:0] NEWLINE_CODE = 16'd10;
	localparam logic [IMG_W-1:0]  IMAGE_RESET  = 15'd256;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_FINISH = 2'd2,
		CMD_LOOKUP = 2'd3
	} cmd_t;

	typedef struct packed {
		logic acc_clear;
		logic acc_load;
		logic acc_finish;
		logic acc_lookup;
		logic div_start;
		logic div_sel;
		logic store_w;
		logic store_h;
		logic scan_start;
		logic scan_run;
		logic mul_en;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic div_done;
	} dp_stat_t;

endpackage

FILE: rtl/core/gal_ifs.sv
// ----------------------------------------------------------------------------
// gal channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gal_req_if;
	logic                              valid;
	logic                              ready;
	gal_pkg::cmd_t                     cmd;
	logic [gal_pkg::CODE_W-1:0]        char_code;

	modport source (output valid, output cmd, output char_code, input ready);
	modport sink   (input valid, input cmd, input char_code, output ready);
endinterface

interface gal_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [gal_pkg::OFS_W-1:0]         x_offset;
	logic [gal_pkg::OFS_W-1:0]         y_offset;
	logic [gal_pkg::IMG_W-1:0]         cell_width;
	logic [gal_pkg::IMG_W-1:0]         cell_height;
	logic                              found;
	logic                              overflow;

	modport source (output valid, output x_offset, output y_offset, output cell_width,
		output cell_height, output found, output overflow, input ready);
	modport sink   (input valid, input x_offset, input y_offset, input cell_width,
		input cell_height, input found, input overflow, output ready);
endinterface

interface gal_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [gal_pkg::CFG_IDX_W-1:0]     reg_index;
	logic [gal_pkg::IMG_W-1:0]         wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: rtl/core/gal_ram.sv
// ----------------------------------------------------------------------------
// gal_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/gal_ctrl.sv
// ----------------------------------------------------------------------------
// gal_ctrl
// Sequencer: accepts requests, runs scan, divide and multiply steps, and
// owns the response valid flag.
// ----------------------------------------------------------------------------
module gal_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  gal_pkg::cmd_t     req_cmd,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output gal_pkg::dp_cmd_t  dp_cmd,
	input  gal_pkg::dp_stat_t dp_stat
);
	import gal_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIVW_GO,
		ST_DIVW,
		ST_DIVH_GO,
		ST_DIVH,
		ST_SCAN_GO,
		ST_SCAN,
		ST_MUL,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   accept;
	logic   out_free;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		dp_cmd            = '0;
		dp_cmd.acc_clear  = accept && (req_cmd == CMD_CLEAR);
		dp_cmd.acc_load   = accept && (req_cmd == CMD_LOAD);
		dp_cmd.acc_finish = accept && (req_cmd == CMD_FINISH);
		dp_cmd.acc_lookup = accept && (req_cmd == CMD_LOOKUP);
		dp_cmd.div_start  = (state_q == ST_DIVW_GO) || (state_q == ST_DIVH_GO);
		dp_cmd.div_sel    = (state_q == ST_DIVH_GO);
		dp_cmd.store_w    = (state_q == ST_DIVW) && dp_stat.div_done;
		dp_cmd.store_h    = (state_q == ST_DIVH) && dp_stat.div_done;
		dp_cmd.scan_start = (state_q == ST_SCAN_GO);
		dp_cmd.scan_run   = (state_q == ST_SCAN);
		dp_cmd.mul_en     = (state_q == ST_MUL);
		dp_cmd.out_load   = (state_q == ST_RESULT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (dp_cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (dp_cmd.acc_finish) begin
						state_q <= ST_DIVW_GO;
					end else if (dp_cmd.acc_lookup) begin
						state_q <= ST_SCAN_GO;
					end
				end
				ST_DIVW_GO: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (dp_stat.div_done) begin
						state_q <= ST_DIVH_GO;
					end
				end
				ST_DIVH_GO: state_q <= ST_DIVH;
				ST_DIVH: begin
					if (dp_stat.div_done) begin
						state_q <= ST_RESULT;
					end
				end
				ST_SCAN_GO: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (dp_stat.scan_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_RESULT;
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/gal_datapath.sv
// ----------------------------------------------------------------------------
// gal_datapath
// Atlas state, entry table, serial entry scan, iterative cell divider,
// offset multipliers and response registers.
// ----------------------------------------------------------------------------
module gal_datapath #(
	parameter int MAX_GLYPHS  = 256,
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLUMNS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [gal_pkg::CODE_W-1:0]    char_code,
	input  logic                          cfg_we,
	input  logic [gal_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gal_pkg::IMG_W-1:0]     cfg_data,
	input  gal_pkg::dp_cmd_t              dp_cmd,
	output gal_pkg::dp_stat_t             dp_stat,
	output logic [gal_pkg::OFS_W-1:0]     x_offset,
	output logic [gal_pkg::OFS_W-1:0]     y_offset,
	output logic [gal_pkg::IMG_W-1:0]     cell_width,
	output logic [gal_pkg::IMG_W-1:0]     cell_height,
	output logic                          found,
	output logic                          overflow
);
	import gal_pkg::*;

	localparam int NW  = $clog2(MAX_GLYPHS + 1);
	localparam int AW  = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CCW = $clog2(MAX_COLUMNS + 1);
	localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int VW  = (RCW > CCW) ? RCW : CCW;
	localparam int EW  = CODE_W + RW + CW;
	localparam int XPW = CW + IMG_W;
	localparam int YPW = RW + IMG_W;

	// configuration
	logic [IMG_W-1:0]  img_w_q;
	logic [IMG_W-1:0]  img_h_q;

	// atlas state
	logic [NW-1:0]     count_q;
	logic [RCW-1:0]    cur_row_q;
	logic [CCW-1:0]    cur_col_q;
	logic [CCW-1:0]    widest_q;
	logic [RCW-1:0]    row_total_q;
	logic [IMG_W-1:0]  cell_w_q;
	logic [IMG_W-1:0]  cell_h_q;
	logic              dropped_q;

	// lookup
	logic [CODE_W-1:0] code_q;
	logic [NW-1:0]     scan_idx_q;
	logic              rd_pend_s1;
	logic              hit_q;
	logic [RW-1:0]     mrow_q;
	logic [CW-1:0]     mcol_q;
	logic [OFS_W-1:0]  x_q;
	logic [OFS_W-1:0]  y_q;

	// divider
	logic [VW-1:0]        div_rem_q;
	logic [IMG_W-1:0]     div_quo_q;
	logic [VW-1:0]        div_dvs_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [VW:0]          div_shift;
	logic [VW:0]          div_diff;
	logic                 div_ge;
	logic                 cell_zero;

	// entry table signals
	logic              row_full;
	logic              col_full;
	logic              is_newline;
	logic              ram_we;
	logic [EW-1:0]     ram_wdata;
	logic [EW-1:0]     ram_rdata;
	logic [CCW-1:0]    col_next;
	logic [RCW:0]      row_sum;
	logic [XPW-1:0]    x_prod;
	logic [YPW-1:0]    y_prod;

	assign row_full   = (cur_row_q >= RCW'(MAX_ROWS));
	assign col_full   = (cur_col_q >= CCW'(MAX_COLUMNS));
	assign is_newline = (char_code == NEWLINE_CODE);
	assign col_next   = cur_col_q + CCW'(1);
	assign ram_we     = dp_cmd.acc_load && !row_full && !is_newline && !col_full
		&& (count_q < NW'(MAX_GLYPHS));
	assign ram_wdata  = {char_code, cur_row_q[RW-1:0], cur_col_q[CW-1:0]};
	assign row_sum    = {1'b0, cur_row_q} + {{RCW{1'b0}}, (cur_col_q != '0)};

	gal_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_GLYPHS)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (ram_wdata),
		.raddr (scan_idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign div_shift = {div_rem_q, div_quo_q[IMG_W-1]};
	assign div_diff  = div_shift - {1'b0, div_dvs_q};
	assign div_ge    = (div_shift >= {1'b0, div_dvs_q});
	assign cell_zero = (widest_q == '0) || (row_total_q == '0);

	assign x_prod = XPW'(mcol_q) * XPW'(cell_w_q);
	assign y_prod = YPW'(mrow_q) * YPW'(cell_h_q);

	assign dp_stat.div_done  = (div_cnt_q == '0);
	assign dp_stat.scan_done = (scan_idx_q >= count_q) && !rd_pend_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= IMAGE_RESET;
			img_h_q <= IMAGE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_IMAGE_WIDTH) begin
				img_w_q <= cfg_data;
			end else if (cfg_index == REG_IMAGE_HEIGHT) begin
				img_h_q <= cfg_data;
			end
		end
	end

	// atlas load state and cell sizes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			widest_q    <= '0;
			row_total_q <= '0;
			cell_w_q    <= '0;
			cell_h_q    <= '0;
			dropped_q   <= 1'b0;
		end else if (dp_cmd.acc_clear) begin
			count_q     <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			widest_q    <= '0;
			row_total_q <= '0;
			cell_w_q    <= '0;
			cell_h_q    <= '0;
			dropped_q   <= 1'b0;
		end else if (dp_cmd.acc_load) begin
			if (row_full) begin
				dropped_q <= 1'b1;
			end else if (is_newline) begin
				cur_row_q <= cur_row_q + RCW'(1);
				cur_col_q <= '0;
			end else if (col_full) begin
				dropped_q <= 1'b1;
			end else begin
				if (ram_we) begin
					count_q <= count_q + NW'(1);
				end else begin
					dropped_q <= 1'b1;
				end
				cur_col_q <= col_next;
				if (col_next > widest_q) begin
					widest_q <= col_next;
				end
			end
		end else if (dp_cmd.acc_finish) begin
			if (row_sum > (RCW + 1)'(MAX_ROWS)) begin
				row_total_q <= RCW'(MAX_ROWS);
			end else begin
				row_total_q <= row_sum[RCW-1:0];
			end
		end else if (dp_cmd.store_w) begin
			cell_w_q <= cell_zero ? '0 : div_quo_q;
		end else if (dp_cmd.store_h) begin
			cell_h_q <= cell_zero ? '0 : div_quo_q;
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (dp_cmd.div_start) begin
			div_cnt_q <= DIV_CNT_W'(IMG_W);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.div_start) begin
			div_rem_q <= '0;
			if (dp_cmd.div_sel) begin
				div_quo_q <= img_h_q;
				div_dvs_q <= VW'(row_total_q);
			end else begin
				div_quo_q <= img_w_q;
				div_dvs_q <= VW'(widest_q);
			end
		end else if (div_cnt_q != '0) begin
			div_rem_q <= div_ge ? div_diff[VW-1:0] : div_shift[VW-1:0];
			div_quo_q <= {div_quo_q[IMG_W-2:0], div_ge};
		end
	end

	// entry scan, last match wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_pend_s1 <= 1'b0;
			hit_q      <= 1'b0;
		end else if (dp_cmd.acc_finish || dp_cmd.scan_start) begin
			scan_idx_q <= '0;
			rd_pend_s1 <= 1'b0;
			hit_q      <= 1'b0;
		end else if (dp_cmd.scan_run) begin
			rd_pend_s1 <= (scan_idx_q < count_q);
			if (scan_idx_q < count_q) begin
				scan_idx_q <= scan_idx_q + NW'(1);
			end
			if (rd_pend_s1 && (ram_rdata[EW-1 -: CODE_W] == code_q)) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.acc_lookup) begin
			code_q <= char_code;
		end
		if (dp_cmd.scan_run && rd_pend_s1 && (ram_rdata[EW-1 -: CODE_W] == code_q)) begin
			mrow_q <= ram_rdata[CW +: RW];
			mcol_q <= ram_rdata[CW-1:0];
		end
		if (dp_cmd.acc_finish) begin
			x_q <= '0;
			y_q <= '0;
		end else if (dp_cmd.mul_en) begin
			x_q <= hit_q ? x_prod[OFS_W-1:0] : '0;
			y_q <= hit_q ? y_prod[OFS_W-1:0] : '0;
		end
		if (dp_cmd.out_load) begin
			x_offset    <= x_q;
			y_offset    <= y_q;
			cell_width  <= cell_w_q;
			cell_height <= cell_h_q;
			found       <= hit_q;
			overflow    <= dropped_q;
		end
	end

endmodule

FILE: rtl/core/glyph_atlas_lookup.sv
// ----------------------------------------------------------------------------
// glyph_atlas_lookup
// Glyph atlas index: character-by-character atlas load, cell size from the
// image size, and code lookup returning the glyph cell pixel offset.
//
// req carries cmd and char_code; clear and load give no
// response. finish and lookup each give one response on rsp.
// cfg writes image_width (index 0) and image_height (index 1); always ready.
// finish runs the shared bit-serial divider once for width and once for
// height. lookup scans the table through the entry RAM read port, one
// entry a cycle.
// req is ready only when no finish or lookup is in progress; a request is
// taken while an earlier response still waits in the rsp output register.
// if rsp stalls, the next response waits in its last step until rsp frees.
// reset: table empty, cell sizes zero, image size registers 256 by 256.
// ----------------------------------------------------------------------------
module glyph_atlas_lookup #(
	parameter int MAX_GLYPHS  = 256,
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLUMNS = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	gal_req_if.sink   req,
	gal_rsp_if.source rsp,
	gal_cfg_if.sink   cfg
);
	import gal_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	assign cfg.ready = 1'b1;

	gal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat)
	);

	gal_datapath #(
		.MAX_GLYPHS  (MAX_GLYPHS),
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_code   (req.char_code),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.reg_index),
		.cfg_data    (cfg.wdata),
		.dp_cmd      (dp_cmd),
		.dp_stat     (dp_stat),
		.x_offset    (rsp.x_offset),
		.y_offset    (rsp.y_offset),
		.cell_width  (rsp.cell_width),
		.cell_height (rsp.cell_height),
		.found       (rsp.found),
		.overflow    (rsp.overflow)
	);

endmodule

FILE: tb/sv/glyph_atlas_lookup_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_atlas_lookup_test
// Self-checking test of the glyph atlas lookup block. Atlases are loaded one
// character at a time, finished and queried. Each finish and lookup answer is
// predicted by an in-bench model of the table and compared field by field.
// Both channels idle at random, and the image size registers are swept
// between phases.
// ----------------------------------------------------------------------------
module glyph_atlas_lookup_test;
	import gal_pkg::*;

	localparam int MAX_GLYPHS  = 256;
	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLUMNS = 64;
	localparam int ITEM_GOAL   = 1050;
	localparam int SETTLE      = 20;

	typedef struct packed {
		logic [OFS_W-1:0] x_offset;
		logic [OFS_W-1:0] y_offset;
		logic [IMG_W-1:0] cell_width;
		logic [IMG_W-1:0] cell_height;
		logic             found;
		logic             overflow;
	} cell_answer_t;

	logic clk;
	logic arst_n;

	gal_req_if req_ch();
	gal_rsp_if rsp_ch();
	gal_cfg_if cfg_ch();

	glyph_atlas_lookup #(
		.MAX_GLYPHS (MAX_GLYPHS),
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLUMNS(MAX_COLUMNS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	// atlas model state
	logic [CODE_W-1:0] glyph_code [MAX_GLYPHS];
	logic [6:0]        glyph_row  [MAX_GLYPHS];
	logic [6:0]        glyph_col  [MAX_GLYPHS];
	logic [8:0]        glyph_count;
	logic [6:0]        row_now;
	logic [6:0]        col_now;
	logic [6:0]        widest;
	logic [6:0]        rows_total;
	logic [IMG_W-1:0]  cell_w;
	logic [IMG_W-1:0]  cell_h;
	logic              overflow_seen;
	logic [IMG_W-1:0]  image_w;
	logic [IMG_W-1:0]  image_h;

	cell_answer_t      pending_answers[$];
	logic [CODE_W-1:0] loaded_codes[$];
	int unsigned       items_sent;
	int unsigned       answers_seen;
	int unsigned       mismatches;
	bit                sender_burst;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit, far above the slowest legal run
	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic void atlas_apply(cmd_t op, logic [CODE_W-1:0] code);
		cell_answer_t answer;
		int unsigned  rows;
		int unsigned  prod;
		answer = '0;
		case (op)
			CMD_CLEAR: begin
				glyph_count   = '0;
				row_now       = '0;
				col_now       = '0;
				widest        = '0;
				rows_total    = '0;
				cell_w        = '0;
				cell_h        = '0;
				overflow_seen = 1'b0;
			end
			CMD_LOAD: begin
				if (row_now >= MAX_ROWS) begin
					overflow_seen = 1'b1;
				end else if (code == NEWLINE_CODE) begin
					row_now++;
					col_now = '0;
				end else if (col_now >= MAX_COLUMNS) begin
					overflow_seen = 1'b1;
				end else begin
					if (glyph_count < MAX_GLYPHS) begin
						glyph_code[glyph_count] = code;
						glyph_row[glyph_count]  = row_now;
						glyph_col[glyph_count]  = col_now;
						glyph_count++;
					end else begin
						overflow_seen = 1'b1;
					end
					col_now++;
					if (col_now > widest)
						widest = col_now;
				end
			end
			CMD_FINISH: begin
				rows = row_now + ((col_now != 0) ? 1 : 0);
				if (rows > MAX_ROWS)
					rows = MAX_ROWS;
				rows_total = rows[6:0];
				if (widest != 0 && rows != 0) begin
					cell_w = image_w / widest;
					cell_h = image_h / rows_total;
				end else begin
					cell_w = '0;
					cell_h = '0;
				end
			end
			CMD_LOOKUP: begin
				for (int i = 0; i < glyph_count; i++) begin
					if (glyph_code[i] == code) begin
						prod = glyph_col[i] * cell_w;
						answer.x_offset = prod[OFS_W-1:0];
						prod = glyph_row[i] * cell_h;
						answer.y_offset = prod[OFS_W-1:0];
						answer.found = 1'b1;
					end
				end
			end
		endcase
		if (op == CMD_FINISH || op == CMD_LOOKUP) begin
			answer.cell_width  = cell_w;
			answer.cell_height = cell_h;
			answer.overflow    = overflow_seen;
			pending_answers = {pending_answers, answer};
		end
	endfunction

	function automatic int idle_gap();
		int r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CODE_W-1:0] next_glyph();
		logic [CODE_W-1:0] code;
		int r = $urandom_range(0, 99);
		if (r < 15 && loaded_codes.size() != 0) begin
			code = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
		end else if (r < 25) begin
			do code = 16'($urandom_range(0, 15)); while (code == NEWLINE_CODE);
		end else begin
			do code = 16'($urandom_range(0, 65535)); while (code == NEWLINE_CODE);
		end
		loaded_codes = {loaded_codes, code};
		return code;
	endfunction

	function automatic logic [CODE_W-1:0] probe_code();
		int r = $urandom_range(0, 99);
		if (r < 75 && loaded_codes.size() != 0)
			return loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
		if (r < 80)
			return NEWLINE_CODE;
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] answer %0d: %s", $time, answers_seen, msg);
		mismatches++;
	endtask

	task automatic compare_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task automatic send_item(cmd_t op, logic [CODE_W-1:0] code);
		int gap;
		gap = sender_burst ? 0 : idle_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.cmd       <= op;
		req_ch.char_code <= code;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		atlas_apply(op, code);
		items_sent++;
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_image(logic [IMG_W-1:0] w, logic [IMG_W-1:0] h);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= REG_IMAGE_WIDTH;
		cfg_ch.wdata     <= w;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		image_w = w;
		cfg_ch.reg_index <= REG_IMAGE_HEIGHT;
		cfg_ch.wdata     <= h;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		image_h = h;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_random_atlas(int max_rows, int max_cols);
		int n_rows;
		int n_cols;
		n_rows = $urandom_range(0, max_rows);
		sender_burst = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 9) != 0) begin
			send_item(CMD_CLEAR, 16'($urandom));
			loaded_codes.delete();
		end
		for (int r = 0; r < n_rows; r++) begin
			n_cols = $urandom_range(0, max_cols);
			for (int c = 0; c < n_cols; c++) begin
				send_item(CMD_LOAD, next_glyph());
				if ($urandom_range(0, 29) == 0)
					send_item(CMD_LOOKUP, probe_code());
				// noise: any command with any code
				if ($urandom_range(0, 39) == 0)
					send_item(cmd_t'($urandom_range(0, 3)), 16'($urandom));
			end
			if (r < n_rows - 1 || $urandom_range(0, 1) == 1)
				send_item(CMD_LOAD, NEWLINE_CODE);
		end
		if ($urandom_range(0, 4) == 0)
			wait_idle();
		send_item(CMD_FINISH, 16'($urandom));
		repeat ($urandom_range(1, 6)) send_item(CMD_LOOKUP, probe_code());
		if ($urandom_range(0, 7) == 0)
			send_item(CMD_FINISH, 16'($urandom));
		sender_burst = 1'b0;
	endtask

	task automatic test_basic_sequences();
		send_item(CMD_LOOKUP, 16'h0041);
		send_item(CMD_FINISH, 16'h0000);
		send_item(CMD_LOAD, 16'h0000);
		send_item(CMD_LOAD, 16'hFFFF);
		send_item(CMD_LOAD, NEWLINE_CODE);
		send_item(CMD_LOAD, NEWLINE_CODE);
		send_item(CMD_LOAD, 16'h0041);
		send_item(CMD_FINISH, 16'hFFFF);
		send_item(CMD_LOOKUP, 16'h0000);
		send_item(CMD_LOOKUP, 16'hFFFF);
		send_item(CMD_LOOKUP, 16'h0041);
		send_item(CMD_LOOKUP, 16'h1234);
		// loading after finish extends the open row
		send_item(CMD_LOAD, 16'h0042);
		send_item(CMD_LOOKUP, 16'h0042);
		send_item(CMD_FINISH, 16'h0000);
		send_item(CMD_LOOKUP, 16'h0042);
		// duplicate code, later entry wins
		send_item(CMD_LOAD, 16'h0000);
		send_item(CMD_FINISH, 16'h0000);
		send_item(CMD_LOOKUP, 16'h0000);
		send_item(CMD_CLEAR, 16'hFFFF);
		send_item(CMD_LOOKUP, 16'h0000);
		// hit before finish with zero cell size
		send_item(CMD_LOAD, 16'h005A);
		send_item(CMD_LOOKUP, 16'h005A);
		send_item(CMD_FINISH, 16'h0000);
		send_item(CMD_LOOKUP, 16'h005A);
	endtask

	task automatic test_image_sizes();
		logic [IMG_W-1:0] widths  [6];
		logic [IMG_W-1:0] heights [6];
		widths  = '{15'd1, 15'd16384, 15'd16384, 15'd1, 15'd0, 15'd256};
		heights = '{15'd1, 15'd16384, 15'd1, 15'd16384, 15'd0, 15'd256};
		widths[4]  = 15'($urandom_range(1, 16384));
		heights[4] = 15'($urandom_range(1, 16384));
		foreach (widths[i]) begin
			wait_idle();
			write_image(widths[i], heights[i]);
			run_random_atlas(4, 6);
		end
	endtask

	task automatic test_column_overflow();
		send_item(CMD_CLEAR, 16'($urandom));
		loaded_codes.delete();
		repeat (MAX_COLUMNS + 6) send_item(CMD_LOAD, next_glyph());
		send_item(CMD_LOAD, NEWLINE_CODE);
		repeat (3) send_item(CMD_LOAD, next_glyph());
		send_item(CMD_FINISH, 16'($urandom));
		repeat (5) send_item(CMD_LOOKUP, probe_code());
	endtask

	task automatic test_row_overflow();
		send_item(CMD_CLEAR, 16'($urandom));
		loaded_codes.delete();
		repeat (2) send_item(CMD_LOAD, next_glyph());
		repeat (MAX_ROWS + 2) send_item(CMD_LOAD, NEWLINE_CODE);
		repeat (2) send_item(CMD_LOAD, next_glyph());
		send_item(CMD_FINISH, 16'($urandom));
		repeat (4) send_item(CMD_LOOKUP, probe_code());
	endtask

	task automatic test_table_full();
		wait_idle();
		write_image(15'd16384, 15'd16384);
		send_item(CMD_CLEAR, 16'($urandom));
		loaded_codes.delete();
		repeat (5) begin
			repeat (60) send_item(CMD_LOAD, next_glyph());
			send_item(CMD_LOAD, NEWLINE_CODE);
		end
		send_item(CMD_FINISH, 16'($urandom));
		repeat (5) send_item(CMD_LOOKUP, probe_code());
	endtask

	task automatic test_random_atlases();
		while (items_sent < ITEM_GOAL) begin
			if ($urandom_range(0, 7) == 0) begin
				wait_idle();
				case ($urandom_range(0, 3))
					0:       write_image(15'd1, 15'($urandom_range(1, 16384)));
					1:       write_image(15'($urandom_range(1, 16384)), 15'd16384);
					default: write_image(15'($urandom_range(1, 16384)),
						15'($urandom_range(1, 16384)));
				endcase
			end
			run_random_atlas(4, 8);
		end
	endtask

	// response side: random stalls with occasional long always-ready runs
	initial begin : rsp_drain
		int gap;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = idle_gap();
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			if ($urandom_range(0, 15) == 0)
				repeat ($urandom_range(50, 150)) @(posedge clk);
			else
				repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin : answer_check
		cell_answer_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("response with no transaction pending");
			end else begin
				want = pending_answers.pop_front();
				compare_field("x_offset", rsp_ch.x_offset, want.x_offset);
				compare_field("y_offset", rsp_ch.y_offset, want.y_offset);
				compare_field("cell_width", rsp_ch.cell_width, want.cell_width);
				compare_field("cell_height", rsp_ch.cell_height, want.cell_height);
				compare_field("found", rsp_ch.found, want.found);
				compare_field("overflow", rsp_ch.overflow, want.overflow);
			end
			answers_seen++;
		end
	end

	initial begin
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.cmd       <= CMD_CLEAR;
		req_ch.char_code <= '0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.reg_index <= REG_IMAGE_WIDTH;
		cfg_ch.wdata     <= '0;
		items_sent    = 0;
		answers_seen  = 0;
		mismatches    = 0;
		sender_burst  = 1'b0;
		image_w       = IMAGE_RESET;
		image_h       = IMAGE_RESET;
		atlas_apply(CMD_CLEAR, '0);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_sequences();
		test_image_sizes();
		test_column_overflow();
		test_row_overflow();
		test_table_full();
		test_random_atlases();

		wait_idle();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
